/* sv/tsic_pkg.sv */
// ----------------------------------------------------------------------------
// tsic_pkg: shared types and constants of the tach speed controller
// Word formats of the sample and result channels, register indexes,
// speed and duty constants, and the sequencer state codes.
// ----------------------------------------------------------------------------
package tsic_pkg;

  // Field widths
  localparam int PERIOD_W = 16;
  localparam int SPEED_W  = 16;
  localparam int DUTY_W   = 14;
  localparam int TARGET_W = 7;
  localparam int SUM_W    = 20;

  // Shared divider: 21-bit dividend, 20-bit divisor, one quotient bit a cycle
  localparam int DIV_W     = 21;
  localparam int DIV_STEPS = DIV_W;
  localparam int STEP_W    = $clog2(DIV_STEPS);

  // Speed and duty constants
  localparam logic [DIV_W-1:0]    SPEED_NUM  = 21'd2000000;
  localparam logic [SPEED_W-1:0]  SPEED_MAX  = 16'hFFFF;
  localparam logic [DUTY_W-1:0]   DUTY_STEP  = 14'd100;
  localparam logic [DUTY_W-1:0]   DUTY_TOP   = 14'd14898;
  localparam logic [DUTY_W-1:0]   DUTY_RESET = 14'd3750;
  localparam logic [DUTY_W-1:0]   DUTY_LIMIT = 14'd14997;
  localparam logic [TARGET_W-1:0] TARGET_RESET = 7'd50;
  localparam logic [SPEED_W:0]    DEAD_BAND  = 17'd3;

  // Register indexes
  localparam logic REG_TARGET_LEFT  = 1'b0;
  localparam logic REG_TARGET_RIGHT = 1'b1;

  // Sample word: one period per wheel
  typedef struct packed {
    logic [PERIOD_W-1:0] left_period;
    logic [PERIOD_W-1:0] right_period;
  } sample_t;

  // Result word: speeds and updated duties
  typedef struct packed {
    logic [SPEED_W-1:0] speed_left;
    logic [SPEED_W-1:0] speed_right;
    logic [DUTY_W-1:0]  drive_left;
    logic [DUTY_W-1:0]  drive_right;
  } result_t;

  // Sequencer states, one-hot
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_AVG_L = 6'b000010,
    S_SPD_L = 6'b000100,
    S_AVG_R = 6'b001000,
    S_SPD_R = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

endpackage

/* sv/tach_speed_incremental_controller.sv */
// ----------------------------------------------------------------------------
// tach_speed_incremental_controller: windowed tach speed and duty stepper
// Sums left and right tach periods over WINDOW samples, then derives the
// speed of each wheel and steps each motor duty toward its target.
// ----------------------------------------------------------------------------
// Usage:
//   sample channel (sample_valid / sample_stall / sample) takes one word per
//   tach reading. A word that does not close a window gives no result. The
//   word that closes a window runs per wheel a reciprocal multiply for the
//   average, then the shared restoring divider for the speed; a finishing
//   state settles the duties. The result is loaded as the duties settle,
//   sample_stall stays high until then, and the next word can be taken once
//   the block is back in idle.
//   result channel (result_valid / result_stall / result) carries one word
//   per window from an output register; samples keep flowing while it waits.
//   If the receiver stalls when a new result is ready, the block holds in
//   its last state until the register frees.
//   cfg_write / cfg_index / cfg_data write the left and right target speeds.
//   Reset (rst, synchronous) clears the sums and count, sets both duties to
//   3750 and both targets to 50 rpm, and empties the output.
// ----------------------------------------------------------------------------
module tach_speed_incremental_controller #(
  parameter int WINDOW = 10
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_write,
  input  logic                         cfg_index,
  input  logic [tsic_pkg::TARGET_W-1:0] cfg_data,
  input  logic                         sample_valid,
  output logic                         sample_stall,
  input  tsic_pkg::sample_t            sample,
  output logic                         result_valid,
  input  logic                         result_stall,
  output tsic_pkg::result_t            result
);

  localparam int CNT_W = $clog2(WINDOW + 1);

  // Reciprocal of the window length, exact for every sum of SUM_W bits
  localparam int REC_L     = $clog2(WINDOW);
  localparam int REC_SHIFT = tsic_pkg::SUM_W + REC_L;
  localparam int REC_W     = tsic_pkg::SUM_W + 1;
  localparam int PROD_W    = tsic_pkg::SUM_W + REC_W;
  localparam logic [REC_W-1:0] REC_MULT =
    REC_W'((64'd1 << REC_SHIFT) / WINDOW + 64'd1);

  tsic_pkg::state_t state;

  logic [tsic_pkg::TARGET_W-1:0] target_left;
  logic [tsic_pkg::TARGET_W-1:0] target_right;
  logic [tsic_pkg::SUM_W-1:0]    sum_left;
  logic [tsic_pkg::SUM_W-1:0]    sum_right;
  logic [CNT_W-1:0]              sample_count;
  logic [tsic_pkg::DUTY_W-1:0]   duty_left;
  logic [tsic_pkg::DUTY_W-1:0]   duty_right;
  logic [tsic_pkg::SPEED_W-1:0]  speed_left;
  logic [tsic_pkg::SPEED_W-1:0]  speed_right;

  // Divider registers
  logic [tsic_pkg::DIV_W-1:0]    dvd;
  logic [tsic_pkg::SUM_W-1:0]    dvs;
  logic [tsic_pkg::SUM_W-1:0]    rem;
  logic [tsic_pkg::STEP_W-1:0]   step;

  logic                          sample_take;
  logic [tsic_pkg::SUM_W-1:0]    sum_left_next;
  logic [tsic_pkg::SUM_W-1:0]    sum_right_next;
  logic [CNT_W-1:0]              count_next;
  logic                          window_end;
  logic                          out_free;
  logic                          step_last;
  logic [tsic_pkg::DIV_W-1:0]    shifted;
  logic                          fits;
  logic [tsic_pkg::SUM_W-1:0]    rem_next;
  logic [tsic_pkg::DIV_W-1:0]    quot_next;
  logic [tsic_pkg::SPEED_W-1:0]  speed_sat;
  logic [tsic_pkg::DUTY_W-1:0]   duty_left_next;
  logic [tsic_pkg::DUTY_W-1:0]   duty_right_next;
  logic [tsic_pkg::SUM_W-1:0]    avg_src;
  logic [PROD_W-1:0]             avg_prod;
  logic [tsic_pkg::SUM_W-1:0]    avg_value;

  // Accumulate the incoming word
  assign sample_stall   = (state != tsic_pkg::S_IDLE);
  assign sample_take    = sample_valid && !sample_stall;
  assign sum_left_next  = sum_left + tsic_pkg::SUM_W'(sample.left_period);
  assign sum_right_next = sum_right + tsic_pkg::SUM_W'(sample.right_period);
  assign count_next     = sample_count + CNT_W'(1);
  assign window_end     = (count_next == CNT_W'(WINDOW));
  assign out_free       = !result_valid || !result_stall;
  assign step_last      = (step == tsic_pkg::STEP_W'(tsic_pkg::DIV_STEPS - 1));

  // Average period of the selected wheel by reciprocal multiply
  assign avg_src   = (state == tsic_pkg::S_AVG_L) ? sum_left : sum_right;
  assign avg_prod  = PROD_W'(avg_src) * PROD_W'(REC_MULT);
  assign avg_value = tsic_pkg::SUM_W'(avg_prod[PROD_W-1:REC_SHIFT]);

  // One restoring divide step; a zero divisor yields an all-ones quotient
  always_comb begin
    shifted   = {rem, dvd[tsic_pkg::DIV_W-1]};
    fits      = (shifted >= {1'b0, dvs});
    rem_next  = fits ? tsic_pkg::SUM_W'(shifted - {1'b0, dvs})
                     : shifted[tsic_pkg::SUM_W-1:0];
    quot_next = {dvd[tsic_pkg::DIV_W-2:0], fits};
  end

  // Clamp the finished quotient to 16 bits
  assign speed_sat = (quot_next[tsic_pkg::DIV_W-1:tsic_pkg::SPEED_W] != '0)
                     ? tsic_pkg::SPEED_MAX : quot_next[tsic_pkg::SPEED_W-1:0];

  // Step a duty toward its target with a dead band of three rpm
  function automatic logic [tsic_pkg::DUTY_W-1:0] step_duty(
    input logic [tsic_pkg::DUTY_W-1:0]   duty,
    input logic [tsic_pkg::SPEED_W-1:0]  speed,
    input logic [tsic_pkg::TARGET_W-1:0] target
  );
    logic [tsic_pkg::SPEED_W:0] s_wide;
    logic [tsic_pkg::SPEED_W:0] t_wide;
    logic [tsic_pkg::DUTY_W-1:0] duty_new;
    s_wide = {1'b0, speed};
    t_wide = (tsic_pkg::SPEED_W + 1)'(target);
    duty_new = duty;
    if ((s_wide > t_wide + tsic_pkg::DEAD_BAND) && (duty > tsic_pkg::DUTY_STEP)) begin
      duty_new = duty - tsic_pkg::DUTY_STEP;
    end else if ((s_wide + tsic_pkg::DEAD_BAND < t_wide) && (duty < tsic_pkg::DUTY_TOP)) begin
      duty_new = duty + tsic_pkg::DUTY_STEP;
    end
    return duty_new;
  endfunction

  assign duty_left_next  = step_duty(duty_left, speed_left, target_left);
  assign duty_right_next = step_duty(duty_right, speed_right, target_right);

  // Write the target registers
  always_ff @(posedge clk) begin
    if (rst) begin
      target_left  <= tsic_pkg::TARGET_RESET;
      target_right <= tsic_pkg::TARGET_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tsic_pkg::REG_TARGET_LEFT:  target_left  <= cfg_data;
        tsic_pkg::REG_TARGET_RIGHT: target_right <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequence the divider runs and the window state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= tsic_pkg::S_IDLE;
      sum_left     <= '0;
      sum_right    <= '0;
      sample_count <= '0;
      duty_left    <= tsic_pkg::DUTY_RESET;
      duty_right   <= tsic_pkg::DUTY_RESET;
      step         <= '0;
    end else begin
      unique case (state)
        tsic_pkg::S_IDLE: begin
          if (sample_take) begin
            sum_left     <= sum_left_next;
            sum_right    <= sum_right_next;
            sample_count <= count_next;
            if (window_end) begin
              state <= tsic_pkg::S_AVG_L;
            end
          end
        end
        tsic_pkg::S_AVG_L, tsic_pkg::S_AVG_R: begin
          // Average becomes the divisor of the speed run
          dvd   <= tsic_pkg::SPEED_NUM;
          dvs   <= avg_value;
          rem   <= '0;
          step  <= '0;
          state <= (state == tsic_pkg::S_AVG_L) ? tsic_pkg::S_SPD_L : tsic_pkg::S_SPD_R;
        end
        tsic_pkg::S_SPD_L, tsic_pkg::S_SPD_R: begin
          if (step_last) begin
            if (state == tsic_pkg::S_SPD_L) begin
              speed_left <= speed_sat;
              state      <= tsic_pkg::S_AVG_R;
            end else begin
              speed_right <= speed_sat;
              state       <= tsic_pkg::S_DONE;
            end
          end else begin
            dvd  <= quot_next;
            rem  <= rem_next;
            step <= step + tsic_pkg::STEP_W'(1);
          end
        end
        tsic_pkg::S_DONE: begin
          // Commit the duties once the output register can take the word
          if (out_free) begin
            duty_left    <= duty_left_next;
            duty_right   <= duty_right_next;
            sum_left     <= '0;
            sum_right    <= '0;
            sample_count <= '0;
            state        <= tsic_pkg::S_IDLE;
          end
        end
        default: state <= tsic_pkg::S_IDLE;
      endcase
    end
  end

  // Hold the result word until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == tsic_pkg::S_DONE && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tsic_pkg::S_DONE && out_free) begin
      result.speed_left  <= speed_left;
      result.speed_right <= speed_right;
      result.drive_left  <= duty_left_next;
      result.drive_right <= duty_right_next;
    end
  end

  // A new result word appears only out of the finishing state
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(state == tsic_pkg::S_DONE))
    else $error("result word loaded outside the finishing state");

  // The window count never reaches the window length between words
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    (state == tsic_pkg::S_IDLE) |-> (sample_count < CNT_W'(WINDOW)))
    else $error("sample count out of range");

  // Duties stay within the stepping limits
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    (duty_left <= tsic_pkg::DUTY_LIMIT) && (duty_right <= tsic_pkg::DUTY_LIMIT))
    else $error("duty beyond its limit");

  // A pending result word holds while stalled
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> (result_valid && $stable(result)))
    else $error("stalled result word changed");

endmodule
